@@ rtl/core/deadline_job_timer_queue_defines.svh @@
// assertion macros for the deadline job timer queue
`ifndef DEADLINE_JOB_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_JOB_TIMER_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DJTQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DJTQ_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DJTQ_ASSERT(label, clk, rstn, prop, msg)
`define DJTQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

@@ rtl/core/djtq_pkg.sv @@
// ----------------------------------------------------------------------------
// djtq_pkg
// types and constants shared by the deadline job timer queue
// ----------------------------------------------------------------------------
package djtq_pkg;
    localparam int NUM_ENTRIES = 16;
    localparam int TIME_BITS   = 48;
    localparam int IDX_BITS    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_BITS    = $clog2(NUM_ENTRIES + 1);
    localparam int FIFO_DEPTH  = 2;

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_CANCEL   = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    localparam logic [2:0] K_INSERTED  = 3'd0;
    localparam logic [2:0] K_MOVED     = 3'd1;
    localparam logic [2:0] K_UNCHANGED = 3'd2;
    localparam logic [2:0] K_FULL      = 3'd3;
    localparam logic [2:0] K_CANCELLED = 3'd4;
    localparam logic [2:0] K_NOT_FOUND = 3'd5;
    localparam logic [2:0] K_FIRED     = 3'd6;
    localparam logic [2:0] K_NOTHING   = 3'd7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  job_id;
        logic [47:0] time_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] result_job;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [7:0]           job_id;
        logic [TIME_BITS-1:0] time_value;
    } job_cmd_t;
endpackage

@@ rtl/core/djtq_front.sv @@
// ----------------------------------------------------------------------------
// djtq_front
// accepts items, drops unused command codes, queues commands for the back end
// ----------------------------------------------------------------------------
module djtq_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  djtq_pkg::in_item_t s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output djtq_pkg::job_cmd_t q_data
);
    import djtq_pkg::*;
    `include "deadline_job_timer_queue_defines.svh"

    localparam int PB = $clog2(FIFO_DEPTH);

    job_cmd_t              mem_reg [FIFO_DEPTH];
    logic [PB-1:0]         wr_reg, rd_reg;
    logic [PB:0]           cnt_reg;
    logic                  push, pop, keep;

    assign s_ready = (cnt_reg != FIFO_DEPTH[PB:0]);
    assign keep    = (s_data.cmd == CMD_SCHEDULE) || (s_data.cmd == CMD_CANCEL)
                     || (s_data.cmd == CMD_TICK);
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_data  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= '{cmd: s_data.cmd, job_id: s_data.job_id,
                                 time_value: s_data.time_value[TIME_BITS-1:0]};
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + {{PB{1'b0}}, push} - {{PB{1'b0}}, pop};
        end
    end

    `DJTQ_ASSERT(a_no_overflow, aclk, aresetn, cnt_reg <= FIFO_DEPTH[PB:0], "queue overflow")
    `DJTQ_ASSERT(a_pop_nonempty, aclk, aresetn, pop |-> cnt_reg != '0, "pop of empty queue")
    `DJTQ_ASSERT(a_full_stall, aclk, aresetn,
        (cnt_reg == FIFO_DEPTH[PB:0] && !pop) |=> cnt_reg == FIFO_DEPTH[PB:0],
        "full queue lost count")
endmodule

@@ rtl/core/djtq_back.sv @@
// ----------------------------------------------------------------------------
// djtq_back
// job table and command sequencer, fires due jobs one per cycle in order while the result output is not stalled
// ----------------------------------------------------------------------------
module djtq_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  djtq_pkg::job_cmd_t  q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output djtq_pkg::out_item_t m_data
);
    import djtq_pkg::*;
    `include "deadline_job_timer_queue_defines.svh"

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_FIRE} state_t;

    state_t               state_reg;
    job_cmd_t             cmd_reg;
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [7:0]           job_reg [NUM_ENTRIES];
    logic [TIME_BITS-1:0] dl_reg  [NUM_ENTRIES];
    logic                 fired_any_reg;
    logic                 out_valid_reg;
    out_item_t            out_reg;

    // match, free and due vectors
    logic [NUM_ENTRIES-1:0] match, due;
    logic                   hit, has_free;
    logic [IDX_BITS-1:0]    hit_idx, free_idx;
    always_comb begin
        hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            match[i] = valid_reg[i] && (job_reg[i] == cmd_reg.job_id);
            due[i]   = valid_reg[i] && (dl_reg[i] <= cmd_reg.time_value);
        end
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin hit = 1'b1; hit_idx = IDX_BITS'(i); end
            if (!valid_reg[i]) begin has_free = 1'b1; free_idx = IDX_BITS'(i); end
        end
    end

    // earliest due entry: best if no other due entry beats it, lower job id wins a tie
    logic [NUM_ENTRIES-1:0] best;
    logic                   any_due;
    logic [IDX_BITS-1:0]    best_idx;
    always_comb begin
        best_idx = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            best[i] = due[i];
            for (int j = 0; j < NUM_ENTRIES; j++) begin
                if (due[j] && j != i && ((dl_reg[j] < dl_reg[i]) ||
                    (dl_reg[j] == dl_reg[i] && job_reg[j] < job_reg[i])))
                    best[i] = 1'b0;
            end
            if (best[i]) best_idx = IDX_BITS'(i);
        end
        any_due = |due;
    end

    logic [NUM_ENTRIES-1:0] due_rest;
    always_comb begin
        due_rest = due;
        due_rest[best_idx] = 1'b0;
    end

    logic out_free;
    logic issue;
    assign out_free = !out_valid_reg || m_ready;
    assign issue    = out_free && (state_reg == ST_EXEC || state_reg == ST_FIRE);
    assign q_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) cmd_reg <= q_data;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            fired_any_reg <= 1'b0;
        end else begin
            if (issue) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        state_reg <= (q_data.cmd == CMD_TICK) ? ST_FIRE : ST_EXEC;
                        fired_any_reg <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        out_reg.result_job <= cmd_reg.job_id;
                        out_reg.last       <= 1'b1;
                        state_reg          <= ST_IDLE;
                        if (cmd_reg.cmd == CMD_CANCEL) begin
                            out_reg.kind <= hit ? K_CANCELLED : K_NOT_FOUND;
                            if (hit) valid_reg[hit_idx] <= 1'b0;
                        end else if (hit) begin
                            if (cmd_reg.time_value < dl_reg[hit_idx]) begin
                                dl_reg[hit_idx] <= cmd_reg.time_value;
                                out_reg.kind    <= K_MOVED;
                            end else begin
                                out_reg.kind <= K_UNCHANGED;
                            end
                        end else if (has_free) begin
                            valid_reg[free_idx] <= 1'b1;
                            job_reg[free_idx]   <= cmd_reg.job_id;
                            dl_reg[free_idx]    <= cmd_reg.time_value;
                            out_reg.kind        <= K_INSERTED;
                        end else begin
                            out_reg.kind <= K_FULL;
                        end
                    end
                end
                ST_FIRE: begin
                    if (out_free) begin
                        if (any_due) begin
                            valid_reg[best_idx] <= 1'b0;
                            out_reg.kind        <= K_FIRED;
                            out_reg.result_job  <= job_reg[best_idx];
                            out_reg.last        <= (due_rest == '0);
                            fired_any_reg       <= 1'b1;
                            if (due_rest == '0) state_reg <= ST_IDLE;
                        end else begin
                            out_reg.kind       <= K_NOTHING;
                            out_reg.result_job <= '0;
                            out_reg.last       <= 1'b1;
                            state_reg          <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `DJTQ_ASSERT(a_one_best, aclk, aresetn,
        (state_reg == ST_FIRE && any_due) |-> $onehot(best), "fire winner not unique")
    `DJTQ_ASSERT(a_no_nothing_after_fire, aclk, aresetn,
        (state_reg == ST_FIRE && fired_any_reg) |-> any_due, "tick ended without last")
    `DJTQ_ASSERT(a_out_hold, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "result dropped under stall")
endmodule

@@ rtl/core/deadline_job_timer_queue.sv @@
// ----------------------------------------------------------------------------
// deadline_job_timer_queue
// table of pending jobs with earliest deadline first firing
// ----------------------------------------------------------------------------
// A schedule or cancel item gives one result once the back end has taken it
// from the two-entry input queue; the back end takes no new item until that
// result is registered. A tick gives one result per cycle while the result
// side keeps up, one per due job, or a single nothing result if none is due;
// the rate is set by the single-issue command sequencer in the back end,
// which picks the earliest due entry by a parallel compare over the table.
// Items with an unused command code are taken and dropped without a result.
module deadline_job_timer_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  djtq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output djtq_pkg::out_item_t m_data
);
    import djtq_pkg::*;

    logic     q_valid, q_ready;
    job_cmd_t q_data;

    djtq_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    djtq_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
